// ===== hw/rtl/rba_pkg.sv =====
// Shared types and constants for the rectangle blit address engine.
// Depends on nothing; imported by rect_blit_address_engine.
`default_nettype none

package rba_pkg;

  // Default coordinate width; sizes carry one more bit.
  localparam int unsigned CoordBitsDefault = 12;

  // Widths fixed by the register map.
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StrideW = 16;
  localparam int unsigned PbW     = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcBase    = 3'd0,
    RegSrcStride  = 3'd1,
    RegDstBase    = 3'd2,
    RegDstStride  = 3'd3,
    RegPixelBytes = 3'd4,
    RegBlitMode   = 3'd5,
    RegFillValue  = 3'd6
  } reg_idx_e;

  typedef enum logic [ModeW-1:0] {
    ModeFill   = 2'd0,
    ModeInvert = 2'd1,
    ModeCopy   = 2'd2
  } blit_mode_e;

  typedef enum logic {
    OpStart = 1'b0,
    OpPixel = 1'b1
  } op_e;

  // Start sequencer: idle, address sum, walk direction.
  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhSum  = 3'b010,
    PhDir  = 3'b100
  } phase_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rect_blit_address_engine.sv =====
// Top level of the rectangle blit address engine: start sequencer, pixel walker
// and output register. Depends on rba_pkg.
`default_nettype none

// A start transfer (tuser = 0) latches a rectangle: the coordinate-times-stride
// products are registered on acceptance, the start addresses are summed in the
// next cycle, and the walk direction and final row offset are settled in PhDir
// after that; the input stalls meanwhile. Then each pixel transfer (tuser = 1)
// gives one registered result, so pixels stream at one per clock whenever the
// output is taken. Copy walks from the last pixel backwards when the source
// start address is not above the destination. Pixel transfers while no
// rectangle is active give no result. Configuration is to be written through
// cfg_we_i while the engine is idle; the block itself does not enforce this.
module rect_blit_address_engine #(
  parameter int unsigned CoordBits = rba_pkg::CoordBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [rba_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [rba_pkg::AddrW-1:0]          cfg_data_i,
  // Input stream.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata, low bit up: src_x, src_y, dst_x, dst_y, rect_width, rect_height,
  // pixel_value, zero fill to whole bytes.
  input  wire logic [((6*CoordBits+34+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: operation.
  input  wire logic                               s_axis_tuser_i,
  // Output stream.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata, low bit up: src_address, dst_address, write_data.
  output logic [3*rba_pkg::AddrW-1:0]             m_axis_tdata_o,
  // tlast: last_pixel.
  output logic                                    m_axis_tlast_o
);
  import rba_pkg::*;

  localparam int unsigned CB    = CoordBits;
  localparam int unsigned SizeW = CB + 1;
  localparam int unsigned OffW  = CB + 3;
  localparam int unsigned ProdW = CB + StrideW;
  localparam int unsigned HProdW = SizeW + StrideW;

  localparam int unsigned SxLo = 0;
  localparam int unsigned SyLo = CB;
  localparam int unsigned DxLo = 2 * CB;
  localparam int unsigned DyLo = 3 * CB;
  localparam int unsigned WLo  = 4 * CB;
  localparam int unsigned HLo  = 4 * CB + SizeW;
  localparam int unsigned PvLo = 4 * CB + 2 * SizeW;

  function automatic logic [OffW-1:0] scale_pb(input logic [SizeW-1:0] v,
                                               input logic [PbW-1:0] pb);
    logic [OffW-1:0] ve;
    ve = OffW'(v);
    case (pb)
      3'd2:    return ve << 1;
      3'd3:    return ve + (ve << 1);
      3'd4:    return ve << 2;
      default: return ve;
    endcase
  endfunction

  // Configuration registers.
  logic [AddrW-1:0]   src_base_q, dst_base_q, fill_value_q;
  logic [StrideW-1:0] src_stride_q, dst_stride_q;
  logic [PbW-1:0]     pixel_bytes_q;
  logic [ModeW-1:0]   blit_mode_q;

  // Walk state.
  phase_e             phase_q, phase_d;
  logic [AddrW-1:0]   src_row_q, src_row_d, dst_row_q, dst_row_d;
  logic [SizeW-1:0]   col_q, col_d, rows_q, rows_d, width_q, width_d;
  logic               desc_q, desc_d, busy_q, busy_d;

  // Start products.
  logic [ProdW-1:0]   sy_prod_q, dy_prod_q;
  logic [OffW-1:0]    sx_off_q, dx_off_q;
  logic [AddrW-1:0]   sh_prod_q, dh_prod_q;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [AddrW-1:0]   out_src_q, out_dst_q, out_data_q;
  logic               out_last_q;

  // Input fields.
  logic [CB-1:0]      in_sx, in_sy, in_dx, in_dy;
  logic [SizeW-1:0]   in_w, in_h, in_hm1;
  logic [AddrW-1:0]   in_pv;

  assign in_sx = s_axis_tdata_i[SxLo +: CB];
  assign in_sy = s_axis_tdata_i[SyLo +: CB];
  assign in_dx = s_axis_tdata_i[DxLo +: CB];
  assign in_dy = s_axis_tdata_i[DyLo +: CB];
  assign in_w  = s_axis_tdata_i[WLo +: SizeW];
  assign in_h  = s_axis_tdata_i[HLo +: SizeW];
  assign in_pv = s_axis_tdata_i[PvLo +: AddrW];
  assign in_hm1 = in_h - SizeW'(1);

  logic in_fire, start_fire, pix_fire;
  assign s_axis_tready_o = (phase_q == PhIdle) && (!out_valid_q || m_axis_tready_i);
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign start_fire = in_fire && (s_axis_tuser_i == OpStart);
  assign pix_fire   = in_fire && (s_axis_tuser_i == OpPixel) && busy_q;

  // Pixel size clamp and byte mask.
  logic [PbW-1:0]   eff_pb;
  logic [AddrW-1:0] pix_mask;
  always_comb begin
    if (pixel_bytes_q == '0) begin
      eff_pb = PbW'(1);
    end else if (pixel_bytes_q > PbW'(4)) begin
      eff_pb = PbW'(4);
    end else begin
      eff_pb = pixel_bytes_q;
    end
    case (eff_pb)
      3'd1:    pix_mask = 32'h0000_00FF;
      3'd2:    pix_mask = 32'h0000_FFFF;
      3'd3:    pix_mask = 32'h00FF_FFFF;
      default: pix_mask = 32'hFFFF_FFFF;
    endcase
  end

  // Pixel datapath.
  logic [SizeW-1:0] pos;
  logic [AddrW-1:0] off32, pix_sa, pix_da, pix_data, pix_rd;
  logic [SizeW:0]   col_inc;
  logic             row_end, pix_last;

  assign pos     = desc_q ? (width_q - SizeW'(1) - col_q) : col_q;
  assign off32   = AddrW'(scale_pb(pos, eff_pb));
  assign pix_sa  = src_row_q + off32;
  assign pix_da  = dst_row_q + off32;
  assign col_inc = {1'b0, col_q} + (SizeW+1)'(1);
  assign row_end = col_inc >= {1'b0, width_q};
  assign pix_last = (col_inc == {1'b0, width_q}) && (rows_q == SizeW'(1));

  always_comb begin
    case (blit_mode_q)
      ModeInvert: begin
        pix_data = ~in_pv & pix_mask;
        pix_rd   = pix_da;
      end
      ModeCopy: begin
        pix_data = in_pv & pix_mask;
        pix_rd   = pix_sa;
      end
      default: begin
        pix_data = fill_value_q & pix_mask;
        pix_rd   = '0;
      end
    endcase
  end

  // Next state of the walker and start sequencer.
  always_comb begin
    phase_d   = phase_q;
    src_row_d = src_row_q;
    dst_row_d = dst_row_q;
    col_d     = col_q;
    rows_d    = rows_q;
    width_d   = width_q;
    desc_d    = desc_q;
    busy_d    = busy_q;
    unique case (phase_q)
      PhIdle: begin
        if (start_fire) begin
          phase_d = PhSum;
          width_d = in_w;
          rows_d  = in_h;
          col_d   = '0;
          busy_d  = 1'b0;
        end else if (pix_fire) begin
          if (row_end) begin
            col_d  = '0;
            rows_d = rows_q - SizeW'(1);
            if (desc_q) begin
              src_row_d = src_row_q - AddrW'(src_stride_q);
              dst_row_d = dst_row_q - AddrW'(dst_stride_q);
            end else begin
              src_row_d = src_row_q + AddrW'(src_stride_q);
              dst_row_d = dst_row_q + AddrW'(dst_stride_q);
            end
            if (rows_q == SizeW'(1)) begin
              busy_d = 1'b0;
            end
          end else begin
            col_d = col_inc[SizeW-1:0];
          end
        end
      end
      PhSum: begin
        phase_d   = PhDir;
        src_row_d = src_base_q + AddrW'(sy_prod_q) + AddrW'(sx_off_q);
        dst_row_d = dst_base_q + AddrW'(dy_prod_q) + AddrW'(dx_off_q);
      end
      PhDir: begin
        phase_d = PhIdle;
        desc_d  = (blit_mode_q == ModeCopy) && !(src_row_q > dst_row_q);
        if (desc_d) begin
          src_row_d = src_row_q + sh_prod_q;
          dst_row_d = dst_row_q + dh_prod_q;
        end
        busy_d = (width_q != '0) && (rows_q != '0);
      end
      default: phase_d = PhIdle;
    endcase
  end

  assign out_valid_d = pix_fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q    <= '0;
      src_stride_q  <= '0;
      dst_base_q    <= '0;
      dst_stride_q  <= '0;
      pixel_bytes_q <= PbW'(1);
      blit_mode_q   <= ModeFill;
      fill_value_q  <= '0;
      phase_q       <= PhIdle;
      src_row_q     <= '0;
      dst_row_q     <= '0;
      col_q         <= '0;
      rows_q        <= '0;
      width_q       <= '0;
      desc_q        <= 1'b0;
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSrcBase:    src_base_q    <= cfg_data_i;
          RegSrcStride:  src_stride_q  <= cfg_data_i[StrideW-1:0];
          RegDstBase:    dst_base_q    <= cfg_data_i;
          RegDstStride:  dst_stride_q  <= cfg_data_i[StrideW-1:0];
          RegPixelBytes: pixel_bytes_q <= cfg_data_i[PbW-1:0];
          RegBlitMode:   blit_mode_q   <= cfg_data_i[ModeW-1:0];
          RegFillValue:  fill_value_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      phase_q     <= phase_d;
      src_row_q   <= src_row_d;
      dst_row_q   <= dst_row_d;
      col_q       <= col_d;
      rows_q      <= rows_d;
      width_q     <= width_d;
      desc_q      <= desc_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Start products and result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_fire) begin
      sy_prod_q <= ProdW'(in_sy) * ProdW'(src_stride_q);
      dy_prod_q <= ProdW'(in_dy) * ProdW'(dst_stride_q);
      sx_off_q  <= scale_pb(SizeW'(in_sx), eff_pb);
      dx_off_q  <= scale_pb(SizeW'(in_dx), eff_pb);
      sh_prod_q <= AddrW'(HProdW'(in_hm1) * HProdW'(src_stride_q));
      dh_prod_q <= AddrW'(HProdW'(in_hm1) * HProdW'(dst_stride_q));
    end
    if (pix_fire) begin
      out_src_q  <= pix_rd;
      out_dst_q  <= pix_da;
      out_data_q <= pix_data;
      out_last_q <= pix_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_data_q, out_dst_q, out_src_q};
  assign m_axis_tlast_o  = out_last_q;

  // The column count stays inside the latched width during a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (col_q < width_q))
    else $error("column count outside rectangle width");

  // The last pixel of a rectangle ends the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_fire && pix_last) |=> !busy_q)
    else $error("walk still active after last pixel");

  // A start runs through PhSum and then PhDir before the next transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fire |=> (phase_q == PhSum) ##1 (phase_q == PhDir))
    else $error("start sequence broken");

  // A pixel transfer with no active rectangle leaves no result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !busy_q && m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("result produced while idle");

endmodule

`default_nettype wire

// ===== test/rect_blit_address_engine_tb.sv =====
// Self-checking testbench for rect_blit_address_engine: a directed stimulus table, then
// random rectangles with idle bursts and back-pressure, scored against a built-in predictor.
// Depends on rba_pkg and the rect_blit_address_engine RTL.
`default_nettype none

module rect_blit_address_engine_tb;
  import rba_pkg::*;

  localparam int unsigned CB  = CoordBitsDefault;
  localparam int unsigned SB  = CB + 1;
  localparam int unsigned InW = ((6 * CB + 34 + 7) / 8) * 8;

  localparam int unsigned OffSy = CB;
  localparam int unsigned OffDx = 2 * CB;
  localparam int unsigned OffDy = 3 * CB;
  localparam int unsigned OffW  = 4 * CB;
  localparam int unsigned OffH  = 4 * CB + SB;
  localparam int unsigned OffPv = 4 * CB + 2 * SB;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic [ModeW-1:0]   ModeSpare = 2'd3;

  localparam int RandItems     = 400;
  localparam int CalmItems     = 60;
  localparam int LatencyCycles = 8;
  localparam int LongHold      = 300;
  localparam int HoldPhase     = 2;
  localparam int DrainLimit    = 20000;

  typedef struct packed {
    op_e            op;
    logic [CB-1:0]  sx;
    logic [CB-1:0]  sy;
    logic [CB-1:0]  dx;
    logic [CB-1:0]  dy;
    logic [SB-1:0]  w;
    logic [SB-1:0]  h;
    logic [31:0]    pv;
  } blit_item_t;

  typedef struct packed {
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [31:0] write_data;
    logic        last_pixel;
  } pixel_write_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        val;
    blit_item_t         item;
    logic               typed;
    pixel_write_t       want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [AddrW-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InW-1:0]       s_axis_tdata_i = '0;
  logic                 s_axis_tuser_i = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [3*AddrW-1:0]   m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  rect_blit_address_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copies of the registers and of the walk state.
  logic [31:0] reg_src_base = '0;
  logic [15:0] reg_src_stride = '0;
  logic [31:0] reg_dst_base = '0;
  logic [15:0] reg_dst_stride = '0;
  logic [2:0]  reg_pixel_bytes = 3'd1;
  logic [1:0]  reg_mode = '0;
  logic [31:0] reg_fill = '0;

  logic [31:0] walk_src_row = '0;
  logic [31:0] walk_dst_row = '0;
  logic [12:0] walk_col = '0;
  logic [12:0] walk_rows = '0;
  logic [12:0] walk_width = '0;
  logic        walk_desc = 1'b0;
  logic        walk_busy = 1'b0;

  pixel_write_t expected_writes[$];
  dir_row_t     directed[$];
  int           fail_count = 0;
  int           rand_items = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;

  function automatic logic [31:0] eff_pixel_bytes();
    if (reg_pixel_bytes == 3'd0) return 32'd1;
    if (reg_pixel_bytes > 3'd4) return 32'd4;
    return 32'(reg_pixel_bytes);
  endfunction

  task automatic write_model_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      RegSrcBase:    reg_src_base = val;
      RegSrcStride:  reg_src_stride = val[15:0];
      RegDstBase:    reg_dst_base = val;
      RegDstStride:  reg_dst_stride = val[15:0];
      RegPixelBytes: reg_pixel_bytes = val[2:0];
      RegBlitMode:   reg_mode = val[1:0];
      RegFillValue:  reg_fill = val;
      default: ;
    endcase
  endtask

  task automatic predict_blit(input blit_item_t it, output bit has, output pixel_write_t res);
    logic [31:0] pb, s0, d0, off, pm;
    logic [12:0] hm1, pos;
    has = 1'b0;
    res = '0;
    pb = eff_pixel_bytes();
    if (it.op == OpStart) begin
      s0 = reg_src_base + 32'(it.sy) * 32'(reg_src_stride) + 32'(it.sx) * pb;
      d0 = reg_dst_base + 32'(it.dy) * 32'(reg_dst_stride) + 32'(it.dx) * pb;
      walk_width = it.w;
      walk_rows = it.h;
      walk_col = '0;
      walk_desc = (reg_mode == ModeCopy) && !(s0 > d0);
      // A descending walk begins on the last row of both rectangles.
      if (walk_desc) begin
        hm1 = (it.h != 13'd0) ? it.h - 13'd1 : 13'd0;
        s0 = s0 + 32'(hm1) * 32'(reg_src_stride);
        d0 = d0 + 32'(hm1) * 32'(reg_dst_stride);
      end
      walk_src_row = s0;
      walk_dst_row = d0;
      walk_busy = (it.w != 13'd0) && (it.h != 13'd0);
    end else if (walk_busy) begin
      pos = walk_desc ? walk_width - 13'd1 - walk_col : walk_col;
      off = 32'(pos) * pb;
      pm = (pb >= 32'd4) ? 32'hFFFF_FFFF : (32'd1 << (8 * pb)) - 32'd1;
      res.dst_address = walk_dst_row + off;
      res.last_pixel = (walk_col + 13'd1 == walk_width) && (walk_rows == 13'd1);
      case (blit_mode_e'(reg_mode))
        ModeInvert: begin
          res.write_data = ~it.pv & pm;
          res.src_address = res.dst_address;
        end
        ModeCopy: begin
          res.write_data = it.pv & pm;
          res.src_address = walk_src_row + off;
        end
        default: begin
          res.write_data = reg_fill & pm;
          res.src_address = 32'd0;
        end
      endcase
      has = 1'b1;
      walk_col = walk_col + 13'd1;
      if (walk_col >= walk_width) begin
        walk_col = '0;
        walk_rows = walk_rows - 13'd1;
        if (walk_desc) begin
          walk_src_row = walk_src_row - 32'(reg_src_stride);
          walk_dst_row = walk_dst_row - 32'(reg_dst_stride);
        end else begin
          walk_src_row = walk_src_row + 32'(reg_src_stride);
          walk_dst_row = walk_dst_row + 32'(reg_dst_stride);
        end
        if (walk_rows == 13'd0) walk_busy = 1'b0;
      end
    end
  endtask

  function automatic logic [InW-1:0] pack_item(input blit_item_t it);
    logic [InW-1:0] d;
    d = '0;
    d[CB-1:0]     = it.sx;
    d[OffSy +: CB] = it.sy;
    d[OffDx +: CB] = it.dx;
    d[OffDy +: CB] = it.dy;
    d[OffW +: SB]  = it.w;
    d[OffH +: SB]  = it.h;
    d[OffPv +: 32] = it.pv;
    return d;
  endfunction

  function automatic blit_item_t random_fields(input op_e op);
    blit_item_t it;
    it.op = op;
    it.sx = CB'($urandom);
    it.sy = CB'($urandom);
    it.dx = CB'($urandom);
    it.dy = CB'($urandom);
    it.w  = SB'($urandom);
    it.h  = SB'($urandom);
    it.pv = $urandom;
    return it;
  endfunction

  task automatic pause_sender(input int n);
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every expected result has arrived, then lets the start
  // sequencer settle before the caller touches the registers.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    write_model_reg(idx, val);
  endtask

  task automatic send_item(input blit_item_t it, output bit has, output pixel_write_t res);
    if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 16));
    cfg_we_i <= 1'b0;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= it.op;
    s_axis_tdata_i <= pack_item(it);
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_blit(it, has, res);
  endtask

  task automatic issue(input blit_item_t it);
    bit           has;
    pixel_write_t res;
    send_item(it, has, res);
    if (has) expected_writes.push_back(res);
    if (it.op == OpStart || has) rand_items++;
    calm = (rand_items >= RandItems - CalmItems);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic configure_random();
    logic [31:0] val;
    logic [31:0] src;
    drain();
    src = pick_word();
    write_reg(RegSrcBase, src);
    val = $urandom;
    val[15:0] = 16'(pick_word());
    write_reg(RegSrcStride, val);
    // Sharing one buffer makes overlapping copies in both directions likely.
    write_reg(RegDstBase, ($urandom_range(0, 2) == 0) ? src : pick_word());
    val = $urandom;
    val[15:0] = 16'(pick_word());
    write_reg(RegDstStride, val);
    val = $urandom;
    val[2:0] = 3'($urandom_range(0, 7));
    write_reg(RegPixelBytes, val);
    val = $urandom;
    val[1:0] = 2'($urandom_range(0, 3));
    write_reg(RegBlitMode, val);
    write_reg(RegFillValue, pick_word());
    if ($urandom_range(0, 4) == 0) write_reg(RegUnused, $urandom);
  endtask

  function automatic dir_row_t reg_row(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t start_row(input int sx, input int sy, input int dx, input int dy,
                                         input int w, input int h);
    dir_row_t r;
    r = '0;
    r.item = random_fields(OpStart);
    r.item.sx = CB'(sx);
    r.item.sy = CB'(sy);
    r.item.dx = CB'(dx);
    r.item.dy = CB'(dy);
    r.item.w = SB'(w);
    r.item.h = SB'(h);
    return r;
  endfunction

  function automatic dir_row_t pixel_row(input logic [31:0] pv);
    dir_row_t r;
    r = '0;
    r.item = random_fields(OpPixel);
    r.item.pv = pv;
    return r;
  endfunction

  function automatic dir_row_t typed_pixel(input logic [31:0] pv, input logic [31:0] sa,
                                           input logic [31:0] da, input logic [31:0] wd,
                                           input logic lp);
    dir_row_t r;
    r = pixel_row(pv);
    r.typed = 1'b1;
    r.want = '{src_address: sa, dst_address: da, write_data: wd, last_pixel: lp};
    return r;
  endfunction

  task automatic check_write();
    pixel_write_t got;
    pixel_write_t want;
    got.src_address = m_axis_tdata_o[31:0];
    got.dst_address = m_axis_tdata_o[63:32];
    got.write_data  = m_axis_tdata_o[95:64];
    got.last_pixel  = m_axis_tlast_o;
    if (expected_writes.size() == 0) begin
      $error("result with no expectation: src_address %h dst_address %h", got.src_address,
             got.dst_address);
      fail_count++;
    end else begin
      want = expected_writes.pop_front();
      if (got.src_address !== want.src_address) begin
        $error("src_address expected %h actual %h", want.src_address, got.src_address);
        fail_count++;
      end
      if (got.dst_address !== want.dst_address) begin
        $error("dst_address expected %h actual %h", want.dst_address, got.dst_address);
        fail_count++;
      end
      if (got.write_data !== want.write_data) begin
        $error("write_data expected %h actual %h", want.write_data, got.write_data);
        fail_count++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel expected %b actual %b", want.last_pixel, got.last_pixel);
        fail_count++;
      end
    end
  endtask

  // Result side: scores each transfer and decides the next tready.
  initial begin
    int hold_left;
    int stall_left;
    logic rdy;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_write();
      if (hold_req) begin
        hold_left = LongHold;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready_i <= rdy;
    end
  end

  initial begin
    #5_000_000;
    $display("rect_blit_address_engine test failed");
    $finish;
  end

  initial begin
    bit           has;
    pixel_write_t res;
    blit_item_t   it;
    int           phase_no;
    int           nrect;
    int           npix;
    int           pick;
    int           wait_cnt;
    bit           big;

    // Reset state: fill with value zero, one byte per pixel, all bases zero.
    directed.push_back(pixel_row($urandom));
    directed.push_back(start_row(0, 0, 0, 0, 1, 1));
    directed.push_back(typed_pixel(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1));
    // Pixel size above four acts as four.
    directed.push_back(reg_row(RegFillValue, 32'hFFFF_FFFF));
    directed.push_back(reg_row(RegPixelBytes, 32'd7));
    directed.push_back(start_row(0, 0, 0, 0, 2, 1));
    directed.push_back(typed_pixel($urandom, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(typed_pixel($urandom, 32'd0, 32'd4, 32'hFFFF_FFFF, 1'b1));
    // Pixel size zero acts as one, and the spare mode acts as fill.
    directed.push_back(reg_row(RegPixelBytes, 32'd0));
    directed.push_back(reg_row(RegBlitMode, 32'(ModeSpare)));
    directed.push_back(start_row(0, 0, 0, 0, 1, 1));
    directed.push_back(typed_pixel($urandom, 32'd0, 32'd0, 32'h0000_00FF, 1'b1));
    directed.push_back(reg_row(RegUnused, 32'h1234_5678));
    // Invert at the top of the address space with the largest strides.
    directed.push_back(reg_row(RegBlitMode, 32'(ModeInvert)));
    directed.push_back(reg_row(RegSrcBase, 32'hFFFF_FFFF));
    directed.push_back(reg_row(RegDstBase, 32'hFFFF_FFFF));
    directed.push_back(reg_row(RegSrcStride, 32'h0000_FFFF));
    directed.push_back(reg_row(RegDstStride, 32'h0000_FFFF));
    directed.push_back(reg_row(RegPixelBytes, 32'd4));
    directed.push_back(start_row(4095, 4095, 4095, 4095, 2, 2));
    directed.push_back(pixel_row(32'h0000_0000));
    directed.push_back(pixel_row(32'hFFFF_FFFF));
    directed.push_back(pixel_row(32'hA5A5_5A5A));
    directed.push_back(pixel_row(32'h1234_5678));
    // Copy within one buffer: equal start addresses walk descending.
    directed.push_back(reg_row(RegBlitMode, 32'(ModeCopy)));
    directed.push_back(reg_row(RegPixelBytes, 32'd3));
    directed.push_back(start_row(1, 2, 1, 2, 3, 2));
    for (int i = 0; i < 6; i++) directed.push_back(pixel_row($urandom));
    // A 4096 by 4096 rectangle, abandoned by a start with no rows.
    directed.push_back(start_row(0, 0, 5, 0, 4096, 4096));
    for (int i = 0; i < 3; i++) directed.push_back(pixel_row($urandom));
    directed.push_back(start_row(7, 7, 7, 7, 5, 0));
    directed.push_back(pixel_row($urandom));
    directed.push_back(start_row(7, 7, 7, 7, 0, 5));
    directed.push_back(pixel_row($urandom));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_item(directed[i].item, has, res);
        if (has) expected_writes.push_back(directed[i].typed ? directed[i].want : res);
      end
    end

    phase_no = 0;
    while (rand_items < RandItems) begin
      configure_random();
      nrect = $urandom_range(1, 4);
      for (int r = 0; r < nrect; r++) begin
        it = random_fields(OpStart);
        big = 1'b0;
        pick = $urandom_range(0, 19);
        if (phase_no == HoldPhase && r == 0) begin
          // The receiver holds off while this rectangle streams in.
          it.w = 13'd10;
          it.h = 13'd10;
          hold_req = 1'b1;
        end else if (pick == 0) begin
          if ($urandom_range(0, 1) == 0) it.w = '0;
          else it.h = '0;
        end else if (pick == 1) begin
          big = 1'b1;
        end else begin
          it.w = SB'($urandom_range(1, 8));
          it.h = SB'($urandom_range(1, 6));
        end
        issue(it);
        if (!walk_busy) npix = $urandom_range(0, 2);
        else if (big) npix = $urandom_range(1, 6);
        else npix = int'(it.w) * int'(it.h);
        for (int p = 0; p < npix; p++) issue(random_fields(OpPixel));
        if ($urandom_range(0, 9) == 0) issue(random_fields(OpPixel));
      end
      // An empty start ends any walk left open before the registers change.
      if (walk_busy) begin
        it = random_fields(OpStart);
        it.w = '0;
        issue(it);
      end
      phase_no++;
    end

    s_axis_tvalid_i <= 1'b0;
    wait_cnt = 0;
    while (expected_writes.size() != 0 && wait_cnt < DrainLimit) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (expected_writes.size() != 0) begin
      $display("rect_blit_address_engine test failed");
    end else begin
      repeat (LatencyCycles) @(posedge clk_i);
      if (fail_count == 0) begin
        $display("rect_blit_address_engine test passed");
      end else begin
        $display("rect_blit_address_engine test failed");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire
